// File: rtl/least_loaded_server_assign_core_macros.svh
// assertion macros for the least-loaded server assignment checker
`ifndef LEAST_LOADED_SERVER_ASSIGN_CORE_MACROS_SVH
`define LEAST_LOADED_SERVER_ASSIGN_CORE_MACROS_SVH

// same-cycle implication under reset
`define LLSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("llsa assertion failed");

// next-cycle implication under reset
`define LLSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("llsa assertion failed");

`endif

// File: rtl/llsa_pkg.sv
// shared constants, types and helpers for the least-loaded server assignment block
package llsa_pkg;

    localparam int MAX_SERVERS = 16;
    localparam int LOAD_WIDTH  = 32;
    localparam int SVC_W       = 16;
    localparam int CFG_W       = 5;
    localparam int ID_W        = 5;
    localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W       = $clog2(MAX_SERVERS + 1);

    localparam logic MODE_CLEAR  = 1'b0;
    localparam logic MODE_ASSIGN = 1'b1;

    typedef logic [LOAD_WIDTH-1:0] t_load;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [ID_W-1:0]       t_id;

    typedef struct packed {
        logic start;
        logic clear;
        logic scan;
        logic update;
        logic load_out;
        logic clear_res;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_status;

    function automatic t_id to_id(input t_idx idx);
        return ID_W'(32'(idx) + 32'd1);
    endfunction

endpackage

// File: rtl/llsa_if.sv
// valid/ready channel interfaces for items and results
interface llsa_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [llsa_pkg::SVC_W-1:0]    service_time;

    modport source (output valid, output mode, output service_time, input ready);
    modport sink   (input valid, input mode, input service_time, output ready);
endinterface

interface llsa_out_if;
    logic                      valid;
    logic                      ready;
    logic [llsa_pkg::ID_W-1:0] assigned_server;
    logic [llsa_pkg::ID_W-1:0] next_server;

    modport source (output valid, output assigned_server, output next_server, input ready);
    modport sink   (input valid, input assigned_server, input next_server, output ready);
endinterface

// File: rtl/llsa_datapath.sv
// busy-time registers, min scan, saturating update and result register
module llsa_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [llsa_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic [llsa_pkg::SVC_W-1:0]  i_svc,
    input  llsa_pkg::t_cmd              i_cmd,
    input  logic                        i_out_ready,
    output llsa_pkg::t_status           o_status,
    output logic                        o_out_valid,
    output llsa_pkg::t_id               o_assigned,
    output llsa_pkg::t_id               o_next
);

    llsa_pkg::t_load                       r_busy [llsa_pkg::MAX_SERVERS];
    logic [llsa_pkg::MAX_SERVERS-1:0]      r_valid;
    llsa_pkg::t_cnt                        r_count;
    llsa_pkg::t_idx                        r_scan_idx;
    llsa_pkg::t_idx                        r_best_idx;
    llsa_pkg::t_load                       r_best_val;
    llsa_pkg::t_idx                        r_sec_idx;
    llsa_pkg::t_load                       r_sec_val;
    logic                                  r_sec_ok;
    logic [llsa_pkg::SVC_W-1:0]            r_svc;
    llsa_pkg::t_load                       r_new_val;
    logic                                  r_out_valid;
    llsa_pkg::t_id                         r_assigned;
    llsa_pkg::t_id                         r_next;

    llsa_pkg::t_cnt                        n_count;
    llsa_pkg::t_load                       scan_val;
    logic [llsa_pkg::LOAD_WIDTH:0]         sum;
    llsa_pkg::t_load                       sat_sum;
    logic                                  keep_best;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_count = llsa_pkg::CNT_W'(1);
        end else if (32'(i_cfg_wdata) > llsa_pkg::MAX_SERVERS) begin
            n_count = llsa_pkg::CNT_W'(llsa_pkg::MAX_SERVERS);
        end else begin
            n_count = llsa_pkg::CNT_W'(i_cfg_wdata);
        end
    end

    assign scan_val = r_valid[r_scan_idx] ? r_busy[r_scan_idx] : '0;
    assign sum      = {1'b0, r_best_val} + (llsa_pkg::LOAD_WIDTH + 1)'(r_svc);
    assign sat_sum  = sum[llsa_pkg::LOAD_WIDTH] ? '1 : sum[llsa_pkg::LOAD_WIDTH-1:0];
    assign keep_best = !r_sec_ok || (r_new_val < r_sec_val)
                       || ((r_new_val == r_sec_val) && (r_best_idx < r_sec_idx));

    assign o_status.scan_last = (llsa_pkg::CNT_W'(r_scan_idx) + llsa_pkg::CNT_W'(1)) == r_count;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_assigned  = r_assigned;
    assign o_next      = r_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= llsa_pkg::CNT_W'(1);
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= n_count;
            end
            if (i_cmd.clear) begin
                r_valid <= '0;
            end else if (i_cmd.update) begin
                r_valid[r_best_idx] <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_svc      <= i_svc;
            r_scan_idx <= '0;
        end
        if (i_cmd.scan) begin
            r_scan_idx <= r_scan_idx + llsa_pkg::IDX_W'(1);
            if (r_scan_idx == '0) begin
                r_best_val <= scan_val;
                r_best_idx <= r_scan_idx;
                r_sec_ok   <= 1'b0;
            end else if (scan_val < r_best_val) begin
                r_sec_val  <= r_best_val;
                r_sec_idx  <= r_best_idx;
                r_sec_ok   <= 1'b1;
                r_best_val <= scan_val;
                r_best_idx <= r_scan_idx;
            end else if (!r_sec_ok || (scan_val < r_sec_val)) begin
                r_sec_val  <= scan_val;
                r_sec_idx  <= r_scan_idx;
                r_sec_ok   <= 1'b1;
            end
        end
        if (i_cmd.update) begin
            r_busy[r_best_idx] <= sat_sum;
            r_new_val          <= sat_sum;
        end
        if (i_cmd.load_out) begin
            if (i_cmd.clear_res) begin
                r_assigned <= '0;
                r_next     <= llsa_pkg::ID_W'(1);
            end else begin
                r_assigned <= llsa_pkg::to_id(r_best_idx);
                r_next     <= keep_best ? llsa_pkg::to_id(r_best_idx)
                                        : llsa_pkg::to_id(r_sec_idx);
            end
        end
    end

endmodule

// File: rtl/llsa_ctrl.sv
// controller state machine sequencing scan, update and result load
module llsa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_mode,
    input  llsa_pkg::t_status  i_status,
    output logic               o_in_ready,
    output llsa_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_clear_item;
    logic   n_clear_item;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        n_clear_item = r_clear_item;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_mode == llsa_pkg::MODE_CLEAR) begin
                        o_cmd.clear  = 1'b1;
                        n_clear_item = 1'b1;
                        n_state      = S_FINISH;
                    end else begin
                        o_cmd.start  = 1'b1;
                        n_clear_item = 1'b0;
                        n_state      = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.clear_res = r_clear_item;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_clear_item <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clear_item <= n_clear_item;
        end
    end

endmodule

// File: rtl/least_loaded_server_assign_core.sv
// Least-loaded server assignment: keeps a saturating busy time per server and
// hands each job to the least busy of the first n servers (n from the server
// count register, 0 taken as 1), lowest number on ties; each transaction gives
// the chosen server and the server the next job would get. An assign
// transaction runs from acceptance through a scan that reads one busy-time
// register per cycle, then an update state and a result state that waits while
// the output register is held; a clear transaction goes straight to the result
// state. One transaction is in flight at a time, and a result waiting in the
// output register does not block acceptance of the next transaction.
module least_loaded_server_assign_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [llsa_pkg::CFG_W-1:0]  i_cfg_wdata,
    llsa_in_if.sink                     i_item,
    llsa_out_if.source                  o_result
);

    llsa_pkg::t_cmd    cmd;
    llsa_pkg::t_status status;

    llsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_mode  (i_item.mode),
        .i_status   (status),
        .o_in_ready (i_item.ready),
        .o_cmd      (cmd)
    );

    llsa_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_svc       (i_item.service_time),
        .i_cmd       (cmd),
        .i_out_ready (o_result.ready),
        .o_status    (status),
        .o_out_valid (o_result.valid),
        .o_assigned  (o_result.assigned_server),
        .o_next      (o_result.next_server)
    );

endmodule

// File: rtl/llsa_checker.sv
// port-level assertion checker for the least-loaded server assignment core
`include "least_loaded_server_assign_core_macros.svh"

module llsa_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_in_mode,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [llsa_pkg::ID_W-1:0]  i_assigned,
    input logic [llsa_pkg::ID_W-1:0]  i_next
);

    // held result stays put while stalled
    `LLSA_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_assigned) && $stable(i_next))

    // a clear result always points at server one
    `LLSA_ASSERT_NOW(a_clear_next, i_out_valid && (i_assigned == '0),
        i_next == llsa_pkg::ID_W'(1))

    // the next server is a real server; the assigned server is zero or a real server
    `LLSA_ASSERT_NOW(a_next_range, i_out_valid,
        (i_next != '0) && (32'(i_next) <= llsa_pkg::MAX_SERVERS)
        && (32'(i_assigned) <= llsa_pkg::MAX_SERVERS))

    // an assign transaction keeps the block busy after acceptance
    `LLSA_ASSERT_NEXT(a_busy_after_assign,
        i_in_valid && i_in_ready && (i_in_mode == llsa_pkg::MODE_ASSIGN), !i_in_ready)

endmodule

bind least_loaded_server_assign_core llsa_checker u_llsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_mode   (i_item.mode),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_assigned  (o_result.assigned_server),
    .i_next      (o_result.next_server)
);
